// File: sv/lsbae_pkg.sv
// Shared types and constants for the audio LSB embedder.
// Used by lsbae_core and lsb_audio_embedder_top; no dependencies.
package lsbae_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned BIT_IDX_W = 3;

    localparam logic [BYTE_W-1:0] LSB_CLEAR       = 8'hFE;
    localparam logic [BYTE_W-1:0] HEADER_LEN_RST  = 8'd54;
    localparam logic [BYTE_W-1:0] TERMINATOR_RST  = 8'd42;

    // Configuration register indexes.
    localparam logic CFG_HEADER_LENGTH   = 1'b0;
    localparam logic CFG_TERMINATOR_BYTE = 1'b1;

    // Input item kinds carried on the slave tuser.
    typedef enum logic [OP_W-1:0] {
        OP_CARRIER = 2'd0,
        OP_LOAD    = 2'd1,
        OP_END     = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNDERRUN = 2'd1,
        ST_REJECT   = 2'd2
    } t_status;

    // Embedding phase.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_MESSAGE = 2'd1,
        PH_TERM    = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    // One result item.
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
    } t_result;

    // Configuration values seen by the core.
    typedef struct packed {
        logic [BYTE_W-1:0] header_length;
        logic [BYTE_W-1:0] terminator_byte;
    } t_cfg;

endpackage

// File: sv/lsbae_core.sv
// Embedding state and per-item result logic of the audio LSB embedder.
// Depends on lsbae_pkg; the result is combinational from the accepted item.
module lsbae_core
    import lsbae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_data,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    t_phase                r_phase, n_phase;
    logic [BYTE_W-1:0]     r_header_count, n_header_count;
    logic [BIT_IDX_W-1:0]  r_bit_index, n_bit_index;
    logic [BYTE_W-1:0]     r_held_byte, n_held_byte;
    logic                  r_byte_pending, n_byte_pending;
    logic                  r_ending, n_ending;

    logic                  w_is_carrier;
    logic                  w_in_header;
    logic                  w_past_header;
    logic                  w_underrun;
    logic                  w_term_start;
    logic                  w_wrap;
    logic [BYTE_W-1:0]     w_src_byte;
    logic                  w_bit;
    logic                  w_cmd_ok;

    // Carrier classification shared by the state and output logic.
    always_comb begin
        w_is_carrier  = (t_op'(i_op) == OP_CARRIER);
        w_in_header   = (r_phase == PH_HEADER) && (r_header_count < i_cfg.header_length);
        w_past_header = (r_phase == PH_HEADER) && !w_in_header;
        w_underrun    = (r_phase == PH_MESSAGE || w_past_header)
                        && !r_byte_pending && !r_ending;
        w_term_start  = (r_phase == PH_MESSAGE || w_past_header)
                        && !r_byte_pending && r_ending;
        w_src_byte    = w_term_start ? i_cfg.terminator_byte : r_held_byte;
        w_bit         = w_src_byte[r_bit_index];
        w_wrap        = (r_bit_index == BIT_IDX_W'(BYTE_W - 1));
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept && w_is_carrier) begin
            if (w_past_header && !w_term_start) begin
                n_phase = PH_MESSAGE;
            end
            if (w_term_start) begin
                n_phase = PH_TERM;
            end else if (r_phase == PH_TERM && w_wrap) begin
                n_phase = PH_DONE;
            end
        end
    end

    // Counters, held byte and result.
    always_comb begin
        n_header_count = r_header_count;
        n_bit_index    = r_bit_index;
        n_held_byte    = r_held_byte;
        n_byte_pending = r_byte_pending;
        n_ending       = r_ending;
        o_result       = '{status: ST_OK, out_byte: '0, out_valid: 1'b0};
        w_cmd_ok       = 1'b0;

        case (t_op'(i_op))
            OP_LOAD: begin
                w_cmd_ok = !r_byte_pending && !r_ending
                           && (r_phase == PH_HEADER || r_phase == PH_MESSAGE);
                if (w_cmd_ok) begin
                    n_held_byte    = i_data;
                    n_bit_index    = '0;
                    n_byte_pending = 1'b1;
                end else begin
                    o_result.status = ST_REJECT;
                end
            end
            OP_END: begin
                w_cmd_ok = !r_ending && (r_phase == PH_HEADER || r_phase == PH_MESSAGE);
                if (w_cmd_ok) begin
                    n_ending = 1'b1;
                end else begin
                    o_result.status = ST_REJECT;
                end
            end
            OP_CARRIER: begin
                o_result.out_valid = 1'b1;
                if (w_in_header) begin
                    n_header_count    = r_header_count + 1'b1;
                    o_result.out_byte = i_data;
                end else if (r_phase == PH_DONE) begin
                    o_result.out_byte = i_data;
                end else if (w_underrun) begin
                    o_result.out_byte = i_data;
                    o_result.status   = ST_UNDERRUN;
                end else begin
                    // Replace the carrier LSB with the next message bit.
                    o_result.out_byte = (i_data & LSB_CLEAR) | {{(BYTE_W-1){1'b0}}, w_bit};
                    n_bit_index       = r_bit_index + 1'b1;
                    if (w_term_start) begin
                        n_held_byte    = i_cfg.terminator_byte;
                        n_byte_pending = 1'b1;
                    end else if (w_wrap) begin
                        n_byte_pending = 1'b0;
                        if (r_phase == PH_TERM) begin
                            n_ending = 1'b0;
                        end
                    end
                end
            end
            default: begin
                o_result.status = ST_REJECT;
            end
        endcase
    end

    // State registers update only on an accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_header_count <= '0;
            r_bit_index    <= '0;
            r_held_byte    <= '0;
            r_byte_pending <= 1'b0;
            r_ending       <= 1'b0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_bit_index    <= n_bit_index;
            r_held_byte    <= n_held_byte;
            r_byte_pending <= n_byte_pending;
            r_ending       <= n_ending;
        end
    end

    // Once done, nothing is pending and the end mark has been consumed.
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (!r_byte_pending && !r_ending))
        else $error("done phase with pending byte or end mark");

    // The terminator is always being embedded while in the terminator phase.
    a_term_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TERM) |-> (r_byte_pending && r_ending))
        else $error("terminator phase without pending terminator");

    // Only an accepted carrier moves the phase.
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(i_accept && t_op'(i_op) == OP_CARRIER))
        |=> (r_phase == $past(r_phase)))
        else $error("phase changed without a carrier transfer");

endmodule

// File: sv/lsb_audio_embedder_top.sv
// Top level of the audio LSB embedder: stream ports, configuration registers
// and a two-entry output register. Depends on lsbae_pkg and lsbae_core.
//
// Usage:
//   Slave stream: tuser carries the operation (carrier, load message byte,
//   end of message), tdata carries the carrier or message byte. Every
//   transfer produces exactly one result transfer on the master stream.
//   Master stream: tdata is the carrier after embedding or passthrough (zero
//   for commands); tuser carries out_valid in bit 0 and status in bits 2:1.
//   The result of an input accepted at an edge is registered in the output
//   register, or in the skid register when the receiver stalls. Throughput is
//   one item per cycle while the receiver takes results; the per-item work is
//   a compare, an increment and a bit insert in front of the output register.
//   When the receiver stalls, a skid register holds one more result, so the
//   slave side keeps taking transfers until both entries are full; slave
//   tready depends only on registered state.
//   Configuration writes (header_length at index 0, terminator_byte at
//   index 1) take effect at the next edge and belong to idle periods.
//   Synchronous reset restores header_length 54 and terminator 42, returns to
//   the header phase and empties the output registers.
module lsb_audio_embedder_top
    import lsbae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port.
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [BYTE_W-1:0] i_cfg_data,
    // Slave stream.
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,    // [7:0] data
    input  logic [OP_W-1:0]   i_s_tuser,    // [1:0] operation
    // Master stream.
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [BYTE_W-1:0] o_m_tdata,    // [7:0] out_byte
    output logic [2:0]        o_m_tuser     // [0] out_valid, [2:1] status
);

    t_cfg    r_cfg;
    t_result w_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_accept;
    logic    w_out_take;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_take = r_out_valid && i_m_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_length   <= HEADER_LEN_RST;
            r_cfg.terminator_byte <= TERMINATOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HEADER_LENGTH:   r_cfg.header_length   <= i_cfg_data;
                CFG_TERMINATOR_BYTE: r_cfg.terminator_byte <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsbae_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_op     (i_s_tuser),
        .i_data   (i_s_tdata),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid  <= r_skid_valid || w_accept;
                r_skid_valid <= 1'b0;
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_take) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end
        if (w_accept && r_out_valid && !w_out_take) begin
            r_skid <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.out_byte;
    assign o_m_tuser  = {r_out.status, r_out.out_valid};

    // The skid entry is only ever filled behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // A stalled transfer with a full skid entry keeps both entries.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_skid_valid && !i_m_tready) |=> (r_skid_valid && r_out_valid))
        else $error("result lost while the receiver stalled");

endmodule
